/* src/midi_voice_allocator_macros.svh */
// Assertion macros for the MIDI voice allocator RTL.
// Depends on aclk and aresetn being visible where a macro is used.
`ifndef MIDI_VOICE_ALLOCATOR_MACROS_SVH
`define MIDI_VOICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MVA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mva_pkg.sv */
// Shared types and constants for the MIDI voice allocator.
// No dependencies.
`default_nettype none
package mva_pkg;
    localparam int MAX_SLOTS = 12;
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    localparam logic [7:0] FREE_NOTE    = 8'hff;
    localparam logic [7:0] CMD_NOTE_ON  = 8'h90;
    localparam logic [7:0] CMD_NOTE_OFF = 8'h80;
    localparam logic [7:0] CMD_POLY_AT  = 8'hA0;
    localparam logic [7:0] CMD_CHAN_AT  = 8'hD0;
    localparam logic [7:0] CHAN_MSG_MAX = 8'hEF;
    localparam logic [7:0] CMD_MASK     = 8'hf0;
    localparam logic [7:0] CHAN_MASK    = 8'h0f;

    typedef enum logic [1:0] {
        CFG_INPUT_CHANNEL = 2'd0,
        CFG_OUTPUT_BASE   = 2'd1,
        CFG_VOICE_COUNT   = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    // Search record handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic [7:0]        note;
        logic              match_found;
        logic [SLOT_W-1:0] match_idx;
        logic              free_found;
        logic [SLOT_W-1:0] free_idx;
        logic [31:0]       best_age;
        logic [SLOT_W-1:0] best_idx;
        logic [7:0]        best_note;
    } probe_t;

    // Slot write from the sequencer.
    typedef struct packed {
        logic              en;
        logic              stamp_en;
        logic [SLOT_W-1:0] idx;
        logic [7:0]        note;
    } slot_wr_t;
endpackage
`default_nettype wire

/* src/midi_voice_allocator.sv */
// MIDI voice allocator with oldest-note stealing.
// Channels: s_ stream takes one MIDI message per transfer; m_ stream gives
// the resulting messages, m_tuser set when the input is forwarded unchanged
// and m_tlast on the final result of each input message.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write input channel, output
// base channel and voice count; write only while the block is idle.
// Path: a forwarded message is held in the candidate registers and then
// loaded into the output register. A channel message walks the row of
// MAX_SLOTS slot cells, one cell a cycle, before its first result is latched
// as a candidate; further results follow one per cycle while the output is free.
// Flow: one message at a time; s_tready is high only while idle, so a new
// message is taken only once the previous one, with all of its results, has
// been fully handled.
// Reset: synchronous, aresetn low; all slots free, stamps and age counter
// cleared, registers at input channel 14, base channel 0, four voices.
// Stall: results hold in the output register while m_tready is low, and the
// sequencer waits unless the result is dropped; no result is lost or repeated.
`default_nettype none
module midi_voice_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // status_byte[7:0], data_one[14:8], data_two[21:15]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_status[7:0], out_data_one[14:8], out_data_two[21:15]
    output logic             m_tuser,   // pass_through[0]
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_wdata
);
`include "midi_voice_allocator_macros.svh"

    localparam int SW = mva_pkg::SLOT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [4:0] in_chan_reg;
    logic [3:0] base_reg;
    logic [3:0] voices_reg;
    logic [mva_pkg::CNT_W-1:0] n_active;

    // latched message
    logic [7:0] sts_reg, sts_next;
    logic [6:0] d1_reg, d1_next;
    logic [6:0] d2_reg, d2_next;

    // pending result candidate
    logic [SW-1:0] cand_slot_reg, cand_slot_next;
    logic [7:0]    cand_cmd_reg, cand_cmd_next;
    logic [6:0]    cand_d1_reg, cand_d1_next;
    logic [6:0]    cand_d2_reg, cand_d2_next;
    logic          cand_last_reg, cand_last_next;
    logic          cand_pass_reg, cand_pass_next;
    logic          steal_reg, steal_next;
    logic          bcast_reg, bcast_next;
    logic [SW-1:0] bcast_end_reg, bcast_end_next;
    logic [31:0]   stamp_reg, stamp_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg, m_data_next;
    logic        m_user_reg, m_user_next;
    logic        m_last_reg, m_last_next;

    mva_pkg::probe_t   chain [mva_pkg::MAX_SLOTS+1];
    mva_pkg::probe_t   res;
    mva_pkg::slot_wr_t wr;

    logic       s_acc;
    logic [7:0] in_sts;
    logic [6:0] in_d1;
    logic       in_chan_msg;
    logic [4:0] ch_sum;
    logic       drop;
    logic       out_free;
    logic [7:0] cmd;
    logic [4:0] chan_lim;
    logic [4:0] n_minus1;

    assign in_sts = s_tdata[7:0];
    assign in_d1  = s_tdata[14:8];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc = s_tvalid && s_tready;
    assign in_chan_msg = in_sts >= mva_pkg::CMD_NOTE_OFF && in_sts <= mva_pkg::CHAN_MSG_MAX
                         && {1'b0, in_sts[3:0]} == in_chan_reg;

    // saturate the voice count to the slot row
    assign n_active = ({1'b0, voices_reg} > 5'(mva_pkg::MAX_SLOTS))
                    ? mva_pkg::CNT_W'(mva_pkg::MAX_SLOTS)
                    : mva_pkg::CNT_W'(voices_reg);

    // start a probe into the chain on every allocator message
    always_comb begin
        chain[0]       = '0;
        chain[0].valid = s_acc && in_chan_msg;
        chain[0].note  = {1'b0, in_d1};
    end

    for (genvar i = 0; i < mva_pkg::MAX_SLOTS; i++) begin : g_cell
        mva_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .idx        (SW'(i)),
            .n_active   (n_active),
            .next_stamp (stamp_reg),
            .wr         (wr),
            .probe_in   (chain[i]),
            .probe_out  (chain[i+1])
        );
    end

    assign res = chain[mva_pkg::MAX_SLOTS];
    assign cmd = sts_reg & mva_pkg::CMD_MASK;
    assign ch_sum = {1'b0, base_reg} + 5'(cand_slot_reg);
    assign drop = !cand_pass_reg && ch_sum[4];
    assign out_free = !m_valid_reg || m_tready;
    assign chan_lim = 5'd15 - {1'b0, base_reg};
    assign n_minus1 = 5'(n_active) - 5'd1;

    always_comb begin
        state_next     = state_reg;
        sts_next       = sts_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        cand_slot_next = cand_slot_reg;
        cand_cmd_next  = cand_cmd_reg;
        cand_d1_next   = cand_d1_reg;
        cand_d2_next   = cand_d2_reg;
        cand_last_next = cand_last_reg;
        cand_pass_next = cand_pass_reg;
        steal_next     = steal_reg;
        bcast_next     = bcast_reg;
        bcast_end_next = bcast_end_reg;
        stamp_next     = stamp_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;
        wr             = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    sts_next = in_sts;
                    d1_next  = in_d1;
                    d2_next  = s_tdata[21:15];
                    if (in_chan_msg) begin
                        state_next = ST_SCAN;
                    end else begin
                        // forward unchanged
                        cand_cmd_next  = in_sts;
                        cand_d1_next   = in_d1;
                        cand_d2_next   = s_tdata[21:15];
                        cand_pass_next = 1'b1;
                        cand_last_next = 1'b1;
                        steal_next     = 1'b0;
                        bcast_next     = 1'b0;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (res.valid) begin
                    cand_pass_next = 1'b0;
                    cand_last_next = 1'b1;
                    steal_next     = 1'b0;
                    bcast_next     = 1'b0;
                    cand_cmd_next  = cmd;
                    cand_d1_next   = d1_reg;
                    cand_d2_next   = d2_reg;
                    state_next     = ST_IDLE;
                    if (cmd == mva_pkg::CMD_NOTE_ON && d2_reg != '0) begin
                        if (n_active != '0) begin
                            state_next = ST_EMIT;
                            if (res.match_found) begin
                                // retrigger, stamp kept
                                cand_slot_next = res.match_idx;
                            end else begin
                                wr.en       = 1'b1;
                                wr.stamp_en = 1'b1;
                                wr.note     = {1'b0, d1_reg};
                                stamp_next  = stamp_reg + 32'd1;
                                if (res.free_found) begin
                                    wr.idx         = res.free_idx;
                                    cand_slot_next = res.free_idx;
                                end else begin
                                    // steal oldest: note off first
                                    wr.idx         = res.best_idx;
                                    cand_slot_next = res.best_idx;
                                    cand_cmd_next  = mva_pkg::CMD_NOTE_OFF;
                                    cand_d1_next   = res.best_note[6:0];
                                    cand_d2_next   = '0;
                                    cand_last_next = 1'b0;
                                    steal_next     = 1'b1;
                                end
                            end
                        end
                    end else if (cmd == mva_pkg::CMD_NOTE_ON || cmd == mva_pkg::CMD_NOTE_OFF) begin
                        if (res.match_found) begin
                            wr.en          = 1'b1;
                            wr.idx         = res.match_idx;
                            wr.note        = mva_pkg::FREE_NOTE;
                            cand_slot_next = res.match_idx;
                            cand_cmd_next  = mva_pkg::CMD_NOTE_OFF;
                            state_next     = ST_EMIT;
                        end
                    end else if (cmd == mva_pkg::CMD_POLY_AT) begin
                        if (res.match_found) begin
                            cand_slot_next = res.match_idx;
                            cand_cmd_next  = mva_pkg::CMD_CHAN_AT;
                            cand_d1_next   = d2_reg;
                            cand_d2_next   = '0;
                            state_next     = ST_EMIT;
                        end
                    end else begin
                        if (n_active != '0) begin
                            // broadcast to every active slot, up to the last one that fits a channel
                            cand_slot_next = '0;
                            bcast_next     = 1'b1;
                            bcast_end_next = (chan_lim < n_minus1) ? SW'(chan_lim)
                                                                   : SW'(n_minus1);
                            cand_last_next = (chan_lim == 5'd0) || (n_minus1 == 5'd0);
                            state_next     = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (drop || out_free) begin
                    if (!drop) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {2'b00, cand_d2_reg, cand_d1_reg,
                                        cand_pass_reg ? cand_cmd_reg
                                                      : {cand_cmd_reg[7:4], ch_sum[3:0]}};
                        m_user_next  = cand_pass_reg;
                        m_last_next  = cand_last_reg;
                    end
                    if (steal_reg) begin
                        // follow the note off with the new note on
                        steal_next     = 1'b0;
                        cand_cmd_next  = mva_pkg::CMD_NOTE_ON;
                        cand_d1_next   = d1_reg;
                        cand_d2_next   = d2_reg;
                        cand_last_next = 1'b1;
                    end else if (bcast_reg && cand_slot_reg != bcast_end_reg
                                 && 5'(cand_slot_reg) < n_minus1) begin
                        cand_slot_next = cand_slot_reg + SW'(1);
                        cand_last_next = (cand_slot_reg + SW'(1)) == bcast_end_reg;
                    end else begin
                        bcast_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_chan_reg <= 5'd14;
            base_reg    <= 4'd0;
            voices_reg  <= 4'd4;
            stamp_reg   <= '0;
            steal_reg   <= 1'b0;
            bcast_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stamp_reg   <= stamp_next;
            steal_reg   <= steal_next;
            bcast_reg   <= bcast_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (mva_pkg::cfg_index_t'(cfg_index))
                    mva_pkg::CFG_INPUT_CHANNEL: in_chan_reg <= cfg_wdata;
                    mva_pkg::CFG_OUTPUT_BASE:   base_reg    <= cfg_wdata[3:0];
                    mva_pkg::CFG_VOICE_COUNT:   voices_reg  <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        sts_reg       <= sts_next;
        d1_reg        <= d1_next;
        d2_reg        <= d2_next;
        cand_slot_reg <= cand_slot_next;
        cand_cmd_reg  <= cand_cmd_next;
        cand_d1_reg   <= cand_d1_next;
        cand_d2_reg   <= cand_d2_next;
        cand_last_reg <= cand_last_next;
        cand_pass_reg <= cand_pass_next;
        bcast_end_reg <= bcast_end_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `MVA_ASSERT_IMPL(a_scan_done_in_scan, res.valid, state_reg == ST_SCAN, "probe left chain outside scan")
    `MVA_ASSERT_NEXT(a_accept_leaves_idle, s_acc, state_reg != ST_IDLE, "accepted item left block idle")
    `MVA_ASSERT_IMPL(a_load_from_emit, $rose(m_valid_reg), $past(state_reg == ST_EMIT), "result loaded outside emit")
endmodule
`default_nettype wire

/* src/mva_cell.sv */
// One voice slot: held note, age stamp and one stage of the search chain.
// Depends on mva_pkg.
`default_nettype none
module mva_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [mva_pkg::SLOT_W-1:0] idx,
    input  wire logic [mva_pkg::CNT_W-1:0]  n_active,
    input  wire logic [31:0]                next_stamp,
    input  wire mva_pkg::slot_wr_t          wr,
    input  wire mva_pkg::probe_t            probe_in,
    output mva_pkg::probe_t                 probe_out
);
    logic [7:0]      note_reg;
    logic [31:0]     stamp_reg;
    mva_pkg::probe_t probe_reg, probe_next;
    logic [31:0]     age;
    logic            in_range;

    assign age = next_stamp - stamp_reg;
    assign in_range = mva_pkg::CNT_W'(idx) < n_active;

    always_comb begin
        probe_next = probe_in;
        if (in_range) begin
            if (!probe_in.match_found && note_reg == probe_in.note) begin
                probe_next.match_found = 1'b1;
                probe_next.match_idx   = idx;
            end
            if (!probe_in.free_found && note_reg == mva_pkg::FREE_NOTE) begin
                probe_next.free_found = 1'b1;
                probe_next.free_idx   = idx;
            end
            // first slot seeds the oldest search; strictly older wins
            if (idx == '0 || age > probe_in.best_age) begin
                probe_next.best_age  = age;
                probe_next.best_idx  = idx;
                probe_next.best_note = note_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_reg  <= mva_pkg::FREE_NOTE;
            stamp_reg <= '0;
            probe_reg <= '0;
        end else begin
            probe_reg <= probe_next;
            if (wr.en && wr.idx == idx) begin
                note_reg <= wr.note;
                if (wr.stamp_en) begin
                    stamp_reg <= next_stamp;
                end
            end
        end
    end

    assign probe_out = probe_reg;
endmodule
`default_nettype wire

/* sim/tb_midi_voice_allocator.sv */
// Self-checking testbench for midi_voice_allocator: drives MIDI messages on the
// s_ stream, predicts the slot allocator's output, checks every m_ transfer.
// Depends on mva_pkg and the midi_voice_allocator RTL.
`default_nettype none
module tb_midi_voice_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic       thru;
        logic       last;
    } midi_out_t;

    typedef struct {
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        bit         has_exp;   // typed-in result for the first output
        midi_out_t  exp;
    } stim_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_wdata = '0;

    midi_voice_allocator dut (.*);

    // Predictor state, mirrors the block after reset.
    logic [4:0]  watch_chan;
    logic [3:0]  base_chan;
    logic [3:0]  voices;
    logic [7:0]  held_note[mva_pkg::MAX_SLOTS];
    logic [31:0] held_stamp[mva_pkg::MAX_SLOTS];
    logic [31:0] stamp_ctr;

    midi_out_t   pending_msgs[$];
    int          error_count = 0;
    int          result_count = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          rx_stall_en = 1;
    bit          tx_idle_en = 1;

    initial begin
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
                 result_count);
        error_count++;
    endtask

    function automatic void reset_voices();
        watch_chan = 5'd14;
        base_chan = 4'd0;
        voices = 4'd4;
        for (int i = 0; i < mva_pkg::MAX_SLOTS; i++) begin
            held_note[i] = mva_pkg::FREE_NOTE;
            held_stamp[i] = '0;
        end
        stamp_ctr = '0;
    endfunction

    // Queue a slot message unless its channel runs past 15.
    function automatic void voice_msg(int slot, logic [7:0] cmd, logic [6:0] a,
                                      logic [6:0] b);
        midi_out_t r;
        int ch;
        ch = base_chan + slot;
        if (ch > 15) return;
        r.status = cmd | 8'(ch);
        r.d1 = a;
        r.d2 = b;
        r.thru = 0;
        r.last = 0;
        pending_msgs.push_back(r);
    endfunction

    function automatic int slot_of(int n, logic [7:0] note);
        for (int i = 0; i < n; i++)
            if (held_note[i] == note) return i;
        return -1;
    endfunction

    // Work out the messages one input causes and advance the voice state.
    function automatic void allocate_voices(logic [7:0] sts, logic [6:0] a, logic [6:0] b);
        logic [7:0]  cmd;
        logic [31:0] age, oldest;
        midi_out_t   r;
        int n, s, before_cnt;
        cmd = sts & mva_pkg::CMD_MASK;
        n = (voices > mva_pkg::MAX_SLOTS) ? mva_pkg::MAX_SLOTS : voices;
        before_cnt = pending_msgs.size();
        if (!(sts >= mva_pkg::CMD_NOTE_OFF && sts <= mva_pkg::CHAN_MSG_MAX &&
              {1'b0, sts[3:0]} == watch_chan)) begin
            r.status = sts; r.d1 = a; r.d2 = b; r.thru = 1; r.last = 1;
            pending_msgs.push_back(r);
            return;
        end
        if (cmd == mva_pkg::CMD_NOTE_ON && b != 0) begin
            if (n == 0) return;
            s = slot_of(n, {1'b0, a});
            if (s >= 0) begin
                voice_msg(s, mva_pkg::CMD_NOTE_ON, a, b);
            end else begin
                s = slot_of(n, mva_pkg::FREE_NOTE);
                if (s < 0) begin
                    oldest = 0;
                    s = 0;
                    for (int i = 0; i < n; i++) begin
                        age = stamp_ctr - held_stamp[i];
                        if (age > oldest) begin
                            oldest = age;
                            s = i;
                        end
                    end
                    voice_msg(s, mva_pkg::CMD_NOTE_OFF, held_note[s][6:0], 7'd0);
                end
                held_note[s] = {1'b0, a};
                held_stamp[s] = stamp_ctr;
                stamp_ctr++;
                voice_msg(s, mva_pkg::CMD_NOTE_ON, a, b);
            end
        end else if (cmd == mva_pkg::CMD_NOTE_ON || cmd == mva_pkg::CMD_NOTE_OFF) begin
            s = slot_of(n, {1'b0, a});
            if (s >= 0) begin
                voice_msg(s, mva_pkg::CMD_NOTE_OFF, a, b);
                held_note[s] = mva_pkg::FREE_NOTE;
            end
        end else if (cmd == mva_pkg::CMD_POLY_AT) begin
            s = slot_of(n, {1'b0, a});
            if (s >= 0) voice_msg(s, mva_pkg::CMD_CHAN_AT, b, 7'd0);
        end else begin
            for (int i = 0; i < n; i++) voice_msg(i, cmd, a, b);
        end
        if (pending_msgs.size() > before_cnt)
            pending_msgs[pending_msgs.size() - 1].last = 1;
    endfunction

    // Result checker and watchdog; sample at the edge, stall in bursts.
    int stall_left = 0;
    always @(posedge aclk) begin
        midi_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (pending_msgs.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = pending_msgs.pop_front();
                if (m_tdata[7:0] !== want.status)
                    report_mismatch("status", m_tdata[7:0], want.status);
                if (m_tdata[14:8] !== want.d1) report_mismatch("data one", m_tdata[14:8], want.d1);
                if (m_tdata[21:15] !== want.d2)
                    report_mismatch("data two", m_tdata[21:15], want.d2);
                if (m_tdata[23:22] !== 2'b00) report_mismatch("pad bits", m_tdata[23:22], 0);
                if (m_tuser !== want.thru) report_mismatch("pass through", m_tuser, want.thru);
                if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
            end
        end
        // Random receiver stalls in bursts.
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end else if (rx_stall_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input mva_pkg::cfg_index_t idx, input logic [4:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            mva_pkg::CFG_INPUT_CHANNEL: watch_chan = val;
            mva_pkg::CFG_OUTPUT_BASE:   base_chan = val[3:0];
            mva_pkg::CFG_VOICE_COUNT:   voices = val[3:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Wait for all expected results, then let a dropped-result walk finish.
    task automatic drain();
        while (pending_msgs.size() != 0) @(posedge aclk);
        repeat (mva_pkg::MAX_SLOTS + 8) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drive one message; hold valid until the transfer, idle in bursts.
    task automatic send_msg(input logic [7:0] sts, input logic [6:0] a, input logic [6:0] b);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b00, b, a, sts};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        allocate_voices(sts, a, b);
        items_sent++;
        s_tvalid <= 0;
        @(posedge aclk);
    endtask

    function automatic stim_row_t row(logic [7:0] s, logic [6:0] a, logic [6:0] b,
                                      bit typed = 0, logic [7:0] es = 0,
                                      logic [6:0] ea = 0, logic [6:0] eb = 0,
                                      logic et = 0, logic el = 0);
        stim_row_t r;
        r.status = s; r.d1 = a; r.d2 = b; r.has_exp = typed;
        r.exp = '{status: es, d1: ea, d2: eb, thru: et, last: el};
        return r;
    endfunction

    // Random message aimed mostly at the watched channel's note traffic.
    task automatic random_msg(input int pool);
        logic [7:0] sts;
        logic [3:0] ch;
        logic [6:0] a;
        int pick;
        pick = $urandom_range(0, 99);
        ch = ($urandom_range(0, 4) != 0 && watch_chan < 16) ? watch_chan[3:0]
                                                             : 4'($urandom);
        a = 7'($urandom_range(60, 60 + pool));
        if (pick < 45)      sts = mva_pkg::CMD_NOTE_ON | ch;
        else if (pick < 70) sts = mva_pkg::CMD_NOTE_OFF | ch;
        else if (pick < 78) sts = mva_pkg::CMD_POLY_AT | ch;
        else if (pick < 88) sts = 8'($urandom_range(8'hB0, 8'hEF) & 8'hF0) | ch;
        else begin
            sts = 8'($urandom);
            a = 7'($urandom);
        end
        send_msg(sts, a, (pick < 45 && $urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom));
    endtask

    initial begin
        stim_row_t dir[$];
        midi_out_t got_first;
        reset_voices();
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset settings (channel 14, base 0, four voices).
        dir.push_back(row(8'h00, 7'd0, 7'd0, 1, 8'h00, 7'd0, 7'd0, 1, 1));
        dir.push_back(row(8'hFF, 7'h7F, 7'h7F, 1, 8'hFF, 7'h7F, 7'h7F, 1, 1));
        dir.push_back(row(8'h9D, 7'd60, 7'd100, 1, 8'h9D, 7'd60, 7'd100, 1, 1));
        dir.push_back(row(8'h9E, 7'd0, 7'd1, 1, 8'h90, 7'd0, 7'd1, 0, 1));
        dir.push_back(row(8'h9E, 7'd127, 7'd127, 1, 8'h91, 7'd127, 7'd127, 0, 1));
        dir.push_back(row(8'h9E, 7'd0, 7'd64));            // retrigger
        dir.push_back(row(8'h9E, 7'd50, 7'd90));
        dir.push_back(row(8'h9E, 7'd51, 7'd90));
        dir.push_back(row(8'h9E, 7'd52, 7'd90));           // steal oldest
        dir.push_back(row(8'hAE, 7'd127, 7'd33, 1, 8'hD1, 7'd33, 7'd0, 0, 1));
        dir.push_back(row(8'hAE, 7'd9, 7'd33));            // not held
        dir.push_back(row(8'h8E, 7'd127, 7'd5, 1, 8'h81, 7'd127, 7'd5, 0, 1));
        dir.push_back(row(8'h9E, 7'd50, 7'd0));            // note on, velocity 0
        dir.push_back(row(8'h8E, 7'd77, 7'd0));            // off, no match
        dir.push_back(row(8'hBE, 7'd7, 7'd100));           // broadcast
        dir.push_back(row(8'hEE, 7'h7F, 7'h00));
        dir.push_back(row(8'hEF, 7'd1, 7'd2, 1, 8'hEF, 7'd1, 7'd2, 1, 1));
        dir.push_back(row(8'hF8, 7'd0, 7'd0, 1, 8'hF8, 7'd0, 7'd0, 1, 1));
        dir.push_back(row(8'h7E, 7'd3, 7'd4, 1, 8'h7E, 7'd3, 7'd4, 1, 1));
        foreach (dir[i]) begin
            if (dir[i].has_exp) begin
                drain();
                send_msg(dir[i].status, dir[i].d1, dir[i].d2);
                got_first = pending_msgs[0];
                if (got_first !== dir[i].exp)
                    report_mismatch($sformatf("table row %0d", i), got_first, dir[i].exp);
            end else begin
                send_msg(dir[i].status, dir[i].d1, dir[i].d2);
            end
        end

        // Extremes: twelve voices past channel 15, zero voices, no watched channel.
        drain();
        write_reg(mva_pkg::CFG_VOICE_COUNT, 5'd15);
        write_reg(mva_pkg::CFG_OUTPUT_BASE, 5'd9);
        write_reg(mva_pkg::CFG_INPUT_CHANNEL, 5'd0);
        send_msg(8'hC0, 7'd5, 7'd0);
        for (int i = 0; i < 14; i++) send_msg(8'h90, 7'(i * 9), 7'd80);
        drain();
        write_reg(mva_pkg::CFG_VOICE_COUNT, 5'd0);
        send_msg(8'h90, 7'd1, 7'd1);
        send_msg(8'h80, 7'd0, 7'd0);
        send_msg(8'hB0, 7'd1, 7'd1);
        drain();
        write_reg(mva_pkg::CFG_INPUT_CHANNEL, 5'd16);
        write_reg(mva_pkg::CFG_VOICE_COUNT, 5'd2);
        send_msg(8'h90, 7'd1, 7'd1);
        drain();

        // Random phases across settings; shrinking voices keeps upper notes parked.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(mva_pkg::CFG_INPUT_CHANNEL,
                      (ph == 5) ? 5'd15 : 5'($urandom_range(0, 16)));
            write_reg(mva_pkg::CFG_OUTPUT_BASE, (ph == 0) ? 5'd15 : (ph == 1) ? 5'd0
                                                  : 5'($urandom_range(0, 15)));
            write_reg(mva_pkg::CFG_VOICE_COUNT, (ph == 2) ? 5'd12 : (ph == 3) ? 5'd1
                                                  : 5'($urandom_range(1, 12)));
            if (ph == 5) begin
                rx_stall_en = 0;
                tx_idle_en = 0;
            end
            for (int k = 0; k < 22; k++) random_msg((ph % 2) ? 6 : 20);
            drain();
        end

        // Output stage for the clock-edge driven m_tready.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d messages, checked %0d results across six channel/voice settings",
                 items_sent, result_count);
        if (error_count == 0 && pending_msgs.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
